### design/avsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avsg_pkg: shared types and constants of the audio/video sync gate
// Queue geometry, field widths, event and command codes, sequencer states.
// ----------------------------------------------------------------------------
package avsg_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int STAMP_W  = 64;
    localparam int HANDLE_W = 32;
    localparam int BYTES_W  = 20;
    localparam int EVENT_W  = 2;
    localparam int FIELD_W  = STAMP_W + HANDLE_W + BYTES_W;
    localparam int DATA_W   = ((FIELD_W + 7) / 8) * 8;
    localparam int OUSER_W  = EVENT_W + 1;

    localparam logic CMD_VIDEO = 1'b0;
    localparam logic CMD_AUDIO = 1'b1;

    localparam logic CFG_VIDEO_EN = 1'b0;
    localparam logic CFG_AUDIO_EN = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_VIDEO = 2'd0,
        EV_AUDIO = 2'd1,
        EV_DROP  = 2'd2
    } t_event;

    typedef struct packed {
        logic signed [STAMP_W-1:0] stamp;
        logic [HANDLE_W-1:0]       handle;
        logic [BYTES_W-1:0]        bytes;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_q_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_ACT,
        ST_VIDEO_EMIT
    } t_state;

endpackage
`default_nettype wire

### design/avsg_stamp_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avsg_stamp_cmp: shared timestamp comparator
// Signed greater-than of two 64-bit presentation timestamps.
// ----------------------------------------------------------------------------
module avsg_stamp_cmp (
    input  wire logic signed [avsg_pkg::STAMP_W-1:0] i_a,
    input  wire logic signed [avsg_pkg::STAMP_W-1:0] i_b,
    output logic                                     o_gt
);
    import avsg_pkg::*;

    assign o_gt = (i_a > i_b);

endmodule
`default_nettype wire

### design/avsg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avsg_queue: audio descriptor ring storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module avsg_queue (
    input  wire logic                          i_clk,
    input  wire avsg_pkg::t_q_wr               i_wr,
    input  wire logic [avsg_pkg::ADDR_W-1:0]   i_rd_addr,
    output avsg_pkg::t_entry                   o_rd_data
);
    import avsg_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### design/audio_video_sync_gate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_video_sync_gate: hold audio descriptors until video catches up
// Forwards video descriptors and releases queued audio in arrival order.
// ----------------------------------------------------------------------------
// One descriptor at a time. An item that produces no release passes through
// accept, drain check and decision; a video item adds a result load after the
// decision (ST_VIDEO_EMIT); each queued audio entry released adds a queue
// read, then compare and output load, since the release loop reads the ring
// at its head with registered read data and runs every decision through a
// single signed 64-bit timestamp comparator. Output stalls hold every step
// that loads a result. A zero byte count is accepted and dropped silently.
// The ring holds QUEUE_DEPTH audio descriptors; audio arriving at a full ring
// is reported as dropped. tlast marks the final result of each input item.
// ----------------------------------------------------------------------------
module audio_video_sync_gate (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_wr_en,
    input  wire logic                          i_cfg_index,
    input  wire logic                          i_cfg_data,
    // input descriptors
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] stamp, [95:64] handle, [115:96] byte_count, [119:116] zero
    input  wire logic [avsg_pkg::DATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  wire logic                          s_axis_tuser,
    // results
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [63:0] out_stamp, [95:64] out_handle, [115:96] out_bytes, [119:116] zero
    output logic [avsg_pkg::DATA_W-1:0]        m_axis_tdata,
    // [1:0] event_res, [2] uploaded
    output logic [avsg_pkg::OUSER_W-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);
    import avsg_pkg::*;

    t_state                 r_state, n_state;
    logic                   r_post, n_post;
    logic                   r_cmd, n_cmd;
    t_entry                 r_item, n_item;
    logic [ADDR_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic                   r_started, n_started;
    logic signed [STAMP_W-1:0] r_lvs, n_lvs;
    logic signed [STAMP_W-1:0] r_las, n_las;
    logic                   r_video_en;
    logic                   r_audio_en;

    logic                   r_m_valid;
    t_entry                 r_m_data;
    t_event                 r_m_event;
    logic                   r_m_up;
    logic                   r_m_last;

    logic                   w_load;
    t_event                 w_ev;
    t_entry                 w_res;
    logic                   w_up;
    logic                   w_last;

    t_q_wr                  w_qwr;
    t_entry                 w_rd;
    logic signed [STAMP_W-1:0] w_cmp_a;
    logic                   w_gt;
    logic                   w_out_free;
    logic [CNT_W-1:0]       w_fill_dec;
    logic                   w_more;
    logic [ADDR_W:0]        w_wsum;
    logic [ADDR_W-1:0]      w_wpos;
    logic [ADDR_W-1:0]      w_head_inc;
    t_entry                 w_in;

    assign w_in.stamp  = s_axis_tdata[STAMP_W-1:0];
    assign w_in.handle = s_axis_tdata[STAMP_W+HANDLE_W-1:STAMP_W];
    assign w_in.bytes  = s_axis_tdata[FIELD_W-1:STAMP_W+HANDLE_W];

    avsg_queue u_queue (
        .i_clk     (i_clk),
        .i_wr      (w_qwr),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd)
    );

    // the released entry is compared while draining, the last audio stamp otherwise
    assign w_cmp_a = (r_state == ST_DRAIN_OUT) ? w_rd.stamp : r_las;

    avsg_stamp_cmp u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (r_lvs),
        .o_gt (w_gt)
    );

    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_fill_dec = r_fill - CNT_W'(1);
    assign w_more     = (w_fill_dec != '0) && !w_gt;
    assign w_wsum     = {1'b0, r_head} + (ADDR_W+1)'(r_fill);
    assign w_wpos     = (w_wsum >= (ADDR_W+1)'(QUEUE_DEPTH))
                        ? w_wsum[ADDR_W-1:0] - ADDR_W'(QUEUE_DEPTH)
                        : w_wsum[ADDR_W-1:0];
    assign w_head_inc = (r_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);

    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_post    = r_post;
        n_cmd     = r_cmd;
        n_item    = r_item;
        n_head    = r_head;
        n_fill    = r_fill;
        n_started = r_started;
        n_lvs     = r_lvs;
        n_las     = r_las;
        w_load    = 1'b0;
        w_ev      = EV_VIDEO;
        w_res     = r_item;
        w_up      = 1'b0;
        w_last    = 1'b0;
        w_qwr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_item = w_in;
                    n_cmd  = s_axis_tuser;
                    if (w_in.bytes != '0) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_started && (r_fill != '0) && !w_gt) begin
                    n_post  = 1'b0;
                    n_state = ST_DRAIN_RD;
                end else begin
                    n_state = ST_ACT;
                end
            end
            ST_DRAIN_RD: begin
                n_state = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    w_ev   = EV_AUDIO;
                    w_res  = w_rd;
                    w_up   = r_audio_en;
                    // look ahead: is this the final result of the item
                    if (r_post) begin
                        w_last = !w_more;
                    end else if (r_cmd == CMD_VIDEO) begin
                        w_last = 1'b0;
                    end else begin
                        w_last = !w_more && (w_fill_dec != '0);
                    end
                    n_las  = w_rd.stamp;
                    n_head = w_head_inc;
                    n_fill = w_fill_dec;
                    if (w_more) begin
                        n_state = ST_DRAIN_RD;
                    end else if (r_post) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_ACT;
                    end
                end
            end
            ST_ACT: begin
                if (r_cmd == CMD_VIDEO) begin
                    n_lvs     = r_item.stamp;
                    n_started = 1'b1;
                    n_state   = ST_VIDEO_EMIT;
                end else if (r_started && (r_fill == '0)) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        w_ev    = EV_AUDIO;
                        w_up    = r_audio_en;
                        w_last  = 1'b1;
                        n_las   = r_item.stamp;
                        n_state = ST_IDLE;
                    end
                end else if (r_fill == CNT_W'(QUEUE_DEPTH)) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        w_ev    = EV_DROP;
                        w_last  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    w_qwr.en   = 1'b1;
                    w_qwr.addr = w_wpos;
                    w_qwr.data = r_item;
                    n_fill     = r_fill + CNT_W'(1);
                    n_state    = ST_IDLE;
                end
            end
            ST_VIDEO_EMIT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    w_ev   = EV_VIDEO;
                    w_up   = r_video_en;
                    w_last = !((r_fill != '0) && !w_gt);
                    if ((r_fill != '0) && !w_gt) begin
                        n_post  = 1'b1;
                        n_state = ST_DRAIN_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_started <= 1'b0;
            r_lvs     <= '0;
            r_las     <= '0;
            r_post    <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_started <= n_started;
            r_lvs     <= n_lvs;
            r_las     <= n_las;
            r_post    <= n_post;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_cmd  <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_en <= 1'b0;
            r_audio_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_VIDEO_EN) begin
                r_video_en <= i_cfg_data;
            end else begin
                r_audio_en <= i_cfg_data;
            end
        end
    end

    // output register: load a result, or drop the valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data  <= w_res;
            r_m_event <= w_ev;
            r_m_up    <= w_up;
            r_m_last  <= w_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(DATA_W - FIELD_W)'(0), r_m_data.bytes, r_m_data.handle,
                            r_m_data.stamp};
    assign m_axis_tuser  = {r_m_up, r_m_event};
    assign m_axis_tlast  = r_m_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN_RD) |-> (r_fill != '0) && r_started)
        else $error("release from empty queue or before video");

    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("video started flag cleared");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded over a pending transaction");

endmodule
`default_nettype wire
